[rtl/pic_pkg.sv]
// ----------------------------------------------------------------------------
// pic_pkg: shared definitions for the polymorphic inline cache
// Cache geometry, mode codes, item kind codes and store write transaction type.
// ----------------------------------------------------------------------------
package pic_pkg;

  localparam int ENTRIES = 4;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam int TYPE_W  = 16;
  localparam int METH_W  = 32;
  localparam int MODE_W  = 2;

  localparam logic [MODE_W-1:0] MODE_MONO = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POLY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MEGA = 2'd2;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [TYPE_W-1:0] type_id;
    logic [METH_W-1:0] method;
  } pic_wr_t;

endpackage

[rtl/polymorphic_inline_cache_unit.sv]
// ----------------------------------------------------------------------------
// polymorphic_inline_cache_unit: single call-site dispatch cache
// Holds up to ENTRIES type/method pairs with fill count and dispatch mode.
// ----------------------------------------------------------------------------
// Operation: a transaction accepted while idle scans the filled entries in
//   turn on the shared comparator, up to the first match (none when empty or
//   megamorphic), then passes through the finish state; out_valid is high in
//   the cycle after finish. A new transaction is not taken while busy; start
//   is taken again while the result strobe is shown. The receiver cannot
//   stall: out_valid is a strobe.
// Reset (rst_n low, synchronous): fill count zero, mode monomorphic, idle.
// ----------------------------------------------------------------------------
module polymorphic_inline_cache_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_kind,
  input  logic [pic_pkg::TYPE_W-1:0]  in_type_id,
  input  logic [pic_pkg::METH_W-1:0]  in_method_handle,
  output logic                        out_valid,
  output logic                        out_hit,
  output logic [pic_pkg::METH_W-1:0]  out_found_method,
  output logic [pic_pkg::MODE_W-1:0]  out_cache_mode
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]                 state_r, state_nxt;
  logic [pic_pkg::CNT_W-1:0]  fill_r, fill_nxt;
  logic [pic_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic [pic_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic                       found_r, found_nxt;

  // Latched transaction
  logic                       kind_r;
  logic [pic_pkg::TYPE_W-1:0] key_r;
  logic [pic_pkg::METH_W-1:0] meth_r;

  logic                       valid_r, valid_nxt;
  logic                       hit_r, hit_nxt;
  logic [pic_pkg::METH_W-1:0] fmeth_r, fmeth_nxt;
  logic [pic_pkg::MODE_W-1:0] omode_r, omode_nxt;

  pic_pkg::pic_wr_t           wr;
  logic                       cmp_match;
  logic [pic_pkg::METH_W-1:0] meth_data;

  logic accept;
  logic last_entry;
  logic full;

  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;
  assign last_entry = ((pic_pkg::CNT_W'(idx_r) + pic_pkg::CNT_W'(1)) == fill_r);
  assign full       = (fill_r == pic_pkg::CNT_W'(pic_pkg::ENTRIES));

  pic_entry_store u_store (
    .clk       (clk),
    .wr        (wr),
    .cmp_idx   (idx_r),
    .cmp_key   (key_r),
    .cmp_match (cmp_match),
    .meth_idx  (idx_r),
    .meth_data (meth_data)
  );

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    mode_nxt   = mode_r;
    idx_nxt    = idx_r;
    found_nxt  = found_r;
    valid_nxt  = 1'b0;
    hit_nxt    = hit_r;
    fmeth_nxt  = fmeth_r;
    omode_nxt  = omode_r;
    wr.en      = 1'b0;
    wr.idx     = fill_r[pic_pkg::IDX_W-1:0];
    wr.type_id = key_r;
    wr.method  = meth_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          idx_nxt   = '0;
          found_nxt = 1'b0;
          // Megamorphic or empty: nothing to compare, go straight to finish.
          if (mode_r == pic_pkg::MODE_MEGA || fill_r == '0) begin
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // One entry per cycle; idx_r stays on the matching slot.
        if (cmp_match) begin
          found_nxt = 1'b1;
          state_nxt = ST_FINISH;
        end else if (last_entry) begin
          state_nxt = ST_FINISH;
        end else begin
          idx_nxt = idx_r + pic_pkg::IDX_W'(1);
        end
      end
      ST_FINISH: begin
        state_nxt = ST_IDLE;
        valid_nxt = 1'b1;
        hit_nxt   = 1'b0;
        fmeth_nxt = '0;
        omode_nxt = mode_r;
        if (kind_r == pic_pkg::KIND_LOOKUP) begin
          if (found_r) begin
            hit_nxt   = 1'b1;
            fmeth_nxt = meth_data;
          end
        end else if (mode_r != pic_pkg::MODE_MEGA && !found_r) begin
          if (!full) begin
            wr.en    = 1'b1;
            fill_nxt = fill_r + pic_pkg::CNT_W'(1);
            // Second entry onward makes the site polymorphic.
            if (fill_r != '0) begin
              mode_nxt  = pic_pkg::MODE_POLY;
              omode_nxt = pic_pkg::MODE_POLY;
            end
          end else begin
            mode_nxt  = pic_pkg::MODE_MEGA;
            omode_nxt = pic_pkg::MODE_MEGA;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      mode_r  <= pic_pkg::MODE_MONO;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      mode_r  <= mode_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    found_r <= found_nxt;
    hit_r   <= hit_nxt;
    fmeth_r <= fmeth_nxt;
    omode_r <= omode_nxt;
    if (accept) begin
      kind_r <= in_kind;
      key_r  <= in_type_id;
      meth_r <= in_method_handle;
    end
  end

  assign out_valid        = valid_r;
  assign out_hit          = hit_r;
  assign out_found_method = fmeth_r;
  assign out_cache_mode   = omode_r;

endmodule

[rtl/pic_entry_store.sv]
// ----------------------------------------------------------------------------
// pic_entry_store: type/method pair storage with one shared type comparator
// One write port, one type read compared against a key, one method read.
// ----------------------------------------------------------------------------
module pic_entry_store (
  input  logic                        clk,
  input  pic_pkg::pic_wr_t            wr,
  input  logic [pic_pkg::IDX_W-1:0]   cmp_idx,
  input  logic [pic_pkg::TYPE_W-1:0]  cmp_key,
  output logic                        cmp_match,
  input  logic [pic_pkg::IDX_W-1:0]   meth_idx,
  output logic [pic_pkg::METH_W-1:0]  meth_data
);

  logic [pic_pkg::TYPE_W-1:0] type_r [pic_pkg::ENTRIES];
  logic [pic_pkg::METH_W-1:0] meth_r [pic_pkg::ENTRIES];

  // Entries beyond the fill count are never compared, so no reset needed.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      type_r[wr.idx] <= wr.type_id;
      meth_r[wr.idx] <= wr.method;
    end
  end

  assign cmp_match = (type_r[cmp_idx] == cmp_key);
  assign meth_data = meth_r[meth_idx];

endmodule
